>>> rtl/core/sorted_key_queue_upsert_range_defines.svh
// Assertion macros shared by the checker of the sorted key queue.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef SORTED_KEY_QUEUE_UPSERT_RANGE_DEFINES_SVH
`define SORTED_KEY_QUEUE_UPSERT_RANGE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SKQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skq check failed");

// Next-cycle implication.
`define SKQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skq check failed");

`endif

>>> rtl/core/skq_pkg.sv
// Types, codes and sizing for the sorted key queue.
// No dependencies; used by every module of the block.
package skq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_RANGE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } cmd_t;

    typedef struct packed {
        logic        success;
        logic [31:0] out_key;
        logic [31:0] out_value;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_UPDATE,
        CELL_INSERT,
        CELL_POP,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t   cmd;
        logic [31:0] key;
        logic [31:0] value;
    } cell_ctl_t;

    typedef struct packed {
        logic   found;
        logic   full;
        entry_t head;
    } skq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

>>> rtl/core/skq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the
// incoming key and takes data from its left or right neighbor. Uses skq_pkg.
module skq_cell
    import skq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    left,
    input  logic      left_gt,
    input  entry_t    right,
    output entry_t    entry,
    output logic      gt,
    output logic      eq
);

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [31:0] value_reg;
    entry_t      entry_next;

    assign entry = '{valid: valid_reg, key: key_reg, value: value_reg};
    // Empty slots count as larger than any key, so the first one takes an insert.
    assign gt    = !valid_reg || (key_reg > ctl.key);
    assign eq    = valid_reg && (key_reg == ctl.key);

    always_comb
    begin
        entry_next = entry;
        case (ctl.cmd)
            CELL_UPDATE:
            begin
                if (eq)
                begin
                    entry_next.value = ctl.value;
                end
            end
            CELL_INSERT:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        entry_next = left;
                    end
                    else
                    begin
                        entry_next = '{valid: 1'b1, key: ctl.key, value: ctl.value};
                    end
                end
            end
            CELL_POP, CELL_ROTATE:
            begin
                entry_next = right;
            end
            default:
            begin
                entry_next = entry;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= entry_next.key;
        value_reg <= entry_next.value;
    end

endmodule

>>> rtl/core/skq_ctrl.sv
// Sequencer of the sorted key queue: decodes transactions, drives the
// chain commands and registers results. Uses skq_pkg.
module skq_ctrl
    import skq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    input  skq_status_t status,
    output cell_ctl_t   cell_ctl,
    output logic        busy,
    output logic        strobe,
    output result_t     result
);

    state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [31:0] pend_key_reg, pend_key_next;
    logic [31:0] pend_value_reg, pend_value_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic        strobe_reg, strobe_next;
    result_t     result_reg, result_next;

    logic        accept;
    logic        match;
    logic        scan_end;

    assign accept   = start && (state_reg == ST_IDLE);
    assign match    = status.head.valid && (status.head.key >= low_reg)
                      && (status.head.key <= high_reg);
    assign scan_end = (count_reg == CNT_W'(CAPACITY - 1));

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.operation == OP_RANGE))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cell_ctl        = '{cmd: CELL_HOLD, key: cmd.key, value: cmd.value};
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_value_next = pend_value_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '{success: 1'b0, out_key: '0, out_value: '0, last: 1'b1};
                    strobe_next = 1'b1;
                    case (cmd.operation)
                        OP_INSERT:
                        begin
                            if (status.found)
                            begin
                                cell_ctl.cmd = CELL_UPDATE;
                            end
                            else if (!status.full)
                            begin
                                cell_ctl.cmd = CELL_INSERT;
                            end
                            result_next.success = status.found || !status.full;
                        end
                        OP_POP:
                        begin
                            cell_ctl.cmd = CELL_POP;
                            if (status.head.valid)
                            begin
                                result_next.success   = 1'b1;
                                result_next.out_key   = status.head.key;
                                result_next.out_value = status.head.value;
                            end
                        end
                        OP_RANGE:
                        begin
                            strobe_next     = 1'b0;
                            count_next      = '0;
                            pend_valid_next = 1'b0;
                            low_next        = cmd.range_low;
                            high_next       = cmd.range_high;
                        end
                        default:
                        begin
                            cell_ctl.cmd = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Chain rotates once around; a match is held back until the next one is
                // seen so the final one can carry last.
                cell_ctl.cmd = CELL_ROTATE;
                count_next   = count_reg + 1'b1;
                if (match)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{success: 1'b1, out_key: pend_key_reg,
                                        out_value: pend_value_reg, last: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_key_next   = status.head.key;
                    pend_value_next = status.head.value;
                end
            end
            ST_FIN:
            begin
                strobe_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next = '{success: 1'b1, out_key: pend_key_reg,
                                    out_value: pend_value_reg, last: 1'b1};
                end
                else
                begin
                    result_next = '{success: 1'b0, out_key: '0, out_value: '0, last: 1'b1};
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_key_reg   <= pend_key_next;
        pend_value_reg <= pend_value_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        result_reg     <= result_next;
    end

endmodule

>>> rtl/core/sorted_key_queue_upsert_range.sv
// Top level of the sorted key queue: a chain of skq_cell slots and the
// skq_ctrl sequencer. Uses skq_pkg.
//
// Usage:
// - A transaction (cmd) is taken at a rising edge with start high and busy low.
// - Results appear on result for one cycle, flagged by strobe; the receiver
//   takes every result and cannot hold them off.
// - Insert/update, pop and the unused code each give one result in the cycle
//   after acceptance, with busy staying low: one transaction per cycle.
// - A range query rotates the entry chain once around, one slot per cycle,
//   with busy high throughout. Matches come out in key order, each held
//   back until the next match is seen at the head; the final result (last
//   match, or a failed result when nothing matched) is on the ports in the
//   cycle in which busy falls.
// - Entries stay sorted by ascending key from slot 0; insert and pop shift the
//   chain by one slot as the transaction is taken.
// - Reset empties the store and returns the sequencer to idle; no clearing
//   pass is needed since every slot carries its own valid flag.
module sorted_key_queue_upsert_range
    import skq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    strobe,
    output result_t result
);

    cell_ctl_t         cell_ctl;
    skq_status_t       status;
    entry_t            ent [CAPACITY];
    logic [CAPACITY-1:0] gt_vec;
    logic [CAPACITY-1:0] eq_vec;

    assign status = '{found: |eq_vec, full: ent[CAPACITY-1].valid, head: ent[0]};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left;
        logic   left_gt;
        entry_t right;

        if (i == 0)
        begin : g_first
            assign left    = '0;
            assign left_gt = 1'b0;
        end
        else
        begin : g_mid_l
            assign left    = ent[i-1];
            assign left_gt = gt_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // Tail wraps to the head while rotating, empties on pop.
            assign right = (cell_ctl.cmd == CELL_ROTATE) ? ent[0] : '0;
        end
        else
        begin : g_mid_r
            assign right = ent[i+1];
        end

        skq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl),
            .left    (left),
            .left_gt (left_gt),
            .right   (right),
            .entry   (ent[i]),
            .gt      (gt_vec[i]),
            .eq      (eq_vec[i])
        );
    end

    skq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .status   (status),
        .cell_ctl (cell_ctl),
        .busy     (busy),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

>>> rtl/core/skq_checker.sv
// Port-level checks for the sorted key queue, attached by bind.
// Uses skq_pkg and sorted_key_queue_upsert_range_defines.svh.
`include "sorted_key_queue_upsert_range_defines.svh"

module skq_checker
    import skq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  cmd_t    cmd,
    input  logic    strobe,
    input  result_t result
);

    logic single_acc;
    logic range_acc;

    assign single_acc = start && !busy && (cmd.operation != OP_RANGE);
    assign range_acc  = start && !busy && (cmd.operation == OP_RANGE);

    `SKQ_ASSERT_NEXT(a_single_result, single_acc, strobe && result.last)
    `SKQ_ASSERT_NEXT(a_range_busy, range_acc, busy && !strobe)
    `SKQ_ASSERT_NOW(a_fail_zero, strobe && !result.success,
        (result.out_key == 32'd0) && (result.out_value == 32'd0) && result.last)
    `SKQ_ASSERT_NOW(a_more_busy, strobe && !result.last, busy && result.success)

endmodule

bind sorted_key_queue_upsert_range skq_checker u_skq_checker (.*);
